FILE: src/mnip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnip_pkg
// Shared types and constants of the MIDI note interval pairer.
// ----------------------------------------------------------------------------
package mnip_pkg;

  localparam int NOTE_COUNT_DEF = 128;

  localparam int KIND_W   = 2;
  localparam int NOTE_W   = 8;
  localparam int VEL_W    = 7;
  localparam int TICK_W   = 32;
  localparam int SPT_W    = 16;
  localparam int SAMPLE_W = 48;
  localparam int STATUS_W = 3;
  localparam int NOTE_OUT_W = 7;
  localparam int ENTRY_W  = SAMPLE_W + VEL_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [SPT_W-1:0] SPT_RESET = 16'd240;

  // register byte addresses, compared on paddr[2]
  localparam logic REG_SPT = 1'b0;

  localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OPEN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ON_ON   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OFF_OFF = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OTHER   = 3'd5;

  typedef struct packed {
    logic take;    // ready for a new item
    logic fetch;   // table read and multiply
    logic commit;  // resolve item, update table, load result
  } mnip_cmd_t;

  typedef struct packed {
    logic evt_valid;
    logic out_free;
  } mnip_stat_t;

endpackage
`default_nettype wire

FILE: src/mnip_evt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnip_evt_if
// Event channel: one MIDI event per item.
// ----------------------------------------------------------------------------
interface mnip_evt_if;
  logic                              valid;
  logic                              ready;
  logic [mnip_pkg::KIND_W-1:0]       kind;
  logic [mnip_pkg::NOTE_W-1:0]       note;
  logic [mnip_pkg::VEL_W-1:0]        velocity;
  logic [mnip_pkg::TICK_W-1:0]       tick_time;

  modport source (output valid, kind, note, velocity, tick_time, input ready);
  modport sink (input valid, kind, note, velocity, tick_time, output ready);
endinterface
`default_nettype wire

FILE: src/mnip_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnip_res_if
// Result channel: one status item per event.
// ----------------------------------------------------------------------------
interface mnip_res_if;
  logic                              valid;
  logic                              ready;
  logic [mnip_pkg::STATUS_W-1:0]     status;
  logic [mnip_pkg::NOTE_OUT_W-1:0]   note_out;
  logic [mnip_pkg::VEL_W-1:0]        velocity_out;
  logic [mnip_pkg::SAMPLE_W-1:0]     start_sample;
  logic [mnip_pkg::SAMPLE_W-1:0]     end_sample;

  modport source (output valid, status, note_out, velocity_out, start_sample, end_sample,
                  input ready);
  modport sink (input valid, status, note_out, velocity_out, start_sample, end_sample,
                output ready);
endinterface
`default_nettype wire

FILE: src/mnip_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mnip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/mnip_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnip_ctrl
// Sequencer: take an item, fetch table entry and scale time, then resolve.
// ----------------------------------------------------------------------------
module mnip_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mnip_pkg::mnip_stat_t stat,
  output      mnip_pkg::mnip_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.evt_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take the item
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_take_then_fetch: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && stat.evt_valid) |=> cmd.fetch)
    else $error("item accepted without a following fetch");

  a_fetch_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> (state == S_EXEC))
    else $error("fetch not followed by resolve");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.fetch, cmd.commit}))
    else $error("more than one command at once");

endmodule
`default_nettype wire

FILE: src/mnip_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnip_datapath
// Event registers, tick scaling, note table and result register.
// ----------------------------------------------------------------------------
module mnip_datapath #(
  parameter int NOTE_COUNT = mnip_pkg::NOTE_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [mnip_pkg::SPT_W-1:0]     spt,
  input  wire mnip_pkg::mnip_cmd_t            cmd,
  output      mnip_pkg::mnip_stat_t           stat,
  mnip_evt_if.sink                            evt,
  mnip_res_if.source                          res
);

  localparam int IDX_W = $clog2(NOTE_COUNT);

  // captured item
  logic [mnip_pkg::KIND_W-1:0]   kind_q;
  logic [mnip_pkg::NOTE_W-1:0]   note_q;
  logic [mnip_pkg::VEL_W-1:0]    vel_q;
  logic [mnip_pkg::TICK_W-1:0]   tick_q;
  logic [mnip_pkg::SAMPLE_W-1:0] sample_q;

  logic [NOTE_COUNT-1:0]         on_bits;
  logic [IDX_W-1:0]              idx;
  logic [mnip_pkg::ENTRY_W-1:0]  rd_entry;
  logic [mnip_pkg::ENTRY_W-1:0]  wr_entry;
  logic [mnip_pkg::SAMPLE_W-1:0] product;

  logic                          is_on;
  logic                          is_off;
  logic                          bad;
  logic                          hit;
  logic                          open_note;
  logic                          close_note;
  logic [mnip_pkg::STATUS_W-1:0]   st_next;
  logic [mnip_pkg::NOTE_OUT_W-1:0] note_next;
  logic [mnip_pkg::VEL_W-1:0]      vel_next;
  logic [mnip_pkg::SAMPLE_W-1:0]   start_next;
  logic [mnip_pkg::SAMPLE_W-1:0]   end_next;

  assign evt.ready      = cmd.take;
  assign stat.evt_valid = evt.valid;
  assign stat.out_free  = !res.valid || res.ready;

  assign idx      = note_q[IDX_W-1:0];
  assign product  = {{(mnip_pkg::SAMPLE_W-mnip_pkg::TICK_W){1'b0}}, tick_q}
                  * {{(mnip_pkg::SAMPLE_W-mnip_pkg::SPT_W){1'b0}}, spt};
  assign wr_entry = {sample_q, vel_q};

  always_ff @(posedge clk) begin
    if (evt.valid && cmd.take) begin
      kind_q <= evt.kind;
      note_q <= evt.note;
      vel_q  <= evt.velocity;
      tick_q <= evt.tick_time;
    end
    if (cmd.fetch) begin
      sample_q <= product;
    end
  end

  mnip_ram #(
    .WIDTH (mnip_pkg::ENTRY_W),
    .DEPTH (NOTE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (cmd.commit && open_note),
    .waddr (idx),
    .wdata (wr_entry),
    .re    (cmd.fetch),
    .raddr (idx),
    .rdata (rd_entry)
  );

  assign is_on  = (kind_q == mnip_pkg::KIND_ON) && (vel_q != '0);
  assign is_off = (kind_q == mnip_pkg::KIND_OFF) || ((kind_q == mnip_pkg::KIND_ON) && (vel_q == '0));
  assign bad    = note_q >= mnip_pkg::NOTE_W'(NOTE_COUNT);
  assign hit    = on_bits[idx];

  always_comb begin
    st_next    = mnip_pkg::ST_OTHER;
    note_next  = '0;
    vel_next   = '0;
    start_next = '0;
    end_next   = '0;
    open_note  = 1'b0;
    close_note = 1'b0;
    if (!is_on && !is_off) begin
      st_next = mnip_pkg::ST_OTHER;
    end else if (bad) begin
      st_next = mnip_pkg::ST_BAD;
    end else if (is_on) begin
      if (hit) begin
        st_next = mnip_pkg::ST_ON_ON;
      end else begin
        st_next    = mnip_pkg::ST_OPEN;
        note_next  = note_q[mnip_pkg::NOTE_OUT_W-1:0];
        vel_next   = vel_q;
        start_next = sample_q;
        open_note  = 1'b1;
      end
    end else if (!hit) begin
      st_next = mnip_pkg::ST_OFF_OFF;
    end else begin
      st_next    = mnip_pkg::ST_DONE;
      note_next  = note_q[mnip_pkg::NOTE_OUT_W-1:0];
      vel_next   = rd_entry[mnip_pkg::VEL_W-1:0];
      start_next = rd_entry[mnip_pkg::ENTRY_W-1:mnip_pkg::VEL_W];
      end_next   = sample_q;
      close_note = 1'b1;
    end
  end

  // one flag per note marks it sounding; table contents count only while set
  always_ff @(posedge clk) begin
    if (rst) begin
      on_bits <= '0;
    end else if (cmd.commit) begin
      if (open_note) begin
        on_bits[idx] <= 1'b1;
      end else if (close_note) begin
        on_bits[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.commit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res.status       <= st_next;
      res.note_out     <= note_next;
      res.velocity_out <= vel_next;
      res.start_sample <= start_next;
      res.end_sample   <= end_next;
    end
  end

  a_one_note_change: assert property (@(posedge clk) disable iff (rst)
    $countones(on_bits) <= $past($countones(on_bits)) + 1)
    else $error("more than one note opened in a cycle");

  a_done_has_velocity: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == mnip_pkg::ST_DONE) |-> (res.velocity_out != '0))
    else $error("completed note with zero velocity");

  a_flag_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == mnip_pkg::ST_BAD || res.status == mnip_pkg::ST_ON_ON
      || res.status == mnip_pkg::ST_OFF_OFF || res.status == mnip_pkg::ST_OTHER))
    |-> (res.note_out == '0 && res.start_sample == '0 && res.end_sample == '0))
    else $error("flagged item carries nonzero fields");

endmodule
`default_nettype wire

FILE: src/midi_note_interval_pairer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_note_interval_pairer_unit
// Pairs MIDI note-on and note-off events into sample-indexed note intervals.
// ----------------------------------------------------------------------------
// an accepted item is registered; the fetch step reads the table and registers
// the scaled time; commit loads the output register. The controller does take,
//   fetch and commit in turn; commit waits while an older result is held
// a new item is taken while the previous result still waits on the output
// reset clears all note flags at once (no clearing pass), samples_per_tick = 240
module midi_note_interval_pairer_unit #(
  parameter int NOTE_COUNT = mnip_pkg::NOTE_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mnip_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mnip_pkg::PDATA_W-1:0]  pwdata,
  output      logic [mnip_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready,
  mnip_evt_if.sink                           evt,
  mnip_res_if.source                         res
);

  logic [mnip_pkg::SPT_W-1:0] spt;
  mnip_pkg::mnip_cmd_t        cmd;
  mnip_pkg::mnip_stat_t       stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mnip_pkg::REG_SPT)
                ? {{(mnip_pkg::PDATA_W-mnip_pkg::SPT_W){1'b0}}, spt} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt <= mnip_pkg::SPT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == mnip_pkg::REG_SPT) begin
      spt <= pwdata[mnip_pkg::SPT_W-1:0];
    end
  end

  mnip_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  mnip_datapath #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .spt  (spt),
    .cmd  (cmd),
    .stat (stat),
    .evt  (evt),
    .res  (res)
  );

endmodule
`default_nettype wire

FILE: tb/mnip_interval_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnip_interval_checker
// Watches the event, result and register ports of the note interval pairer,
// keeps its own note table to predict the status item of every event and
// compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module mnip_interval_checker
  import mnip_pkg::*;
#(
  parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  mnip_evt_if                evt,
  mnip_res_if                res,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [PADDR_W-1:0] SPT_ADDR = {REG_SPT, 2'b00};

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [NOTE_OUT_W-1:0] note;
    logic [VEL_W-1:0]      vel;
    logic [SAMPLE_W-1:0]   start_smp;
    logic [SAMPLE_W-1:0]   stop_smp;
  } interval_t;

  interval_t           interval_q[$];
  logic [SAMPLE_W-1:0] open_start [NOTE_COUNT];
  logic [VEL_W-1:0]    open_vel [NOTE_COUNT];
  logic [SPT_W-1:0]    spt;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic interval_t pair_event(input logic [KIND_W-1:0] kind,
                                           input logic [NOTE_W-1:0] note,
                                           input logic [VEL_W-1:0] vel,
                                           input logic [TICK_W-1:0] tick);
    interval_t           r;
    logic [SAMPLE_W-1:0] tick_w;
    logic [SAMPLE_W-1:0] spt_w;
    logic [SAMPLE_W-1:0] smp;
    logic                is_on;
    logic                is_off;
    int                  idx;
    r = '0;
    tick_w = SAMPLE_W'(tick);
    spt_w = SAMPLE_W'(spt);
    smp = tick_w * spt_w;
    // a note-on with zero velocity counts as a note-off
    is_on = (kind == KIND_ON) && (vel != '0);
    is_off = (kind == KIND_OFF) || ((kind == KIND_ON) && (vel == '0));
    idx = int'(note);
    if (!is_on && !is_off) begin
      r.status = ST_OTHER;
    end else if (note >= NOTE_COUNT) begin
      r.status = ST_BAD;
    end else if (is_on) begin
      if (open_vel[idx] != '0) begin
        r.status = ST_ON_ON;
      end else begin
        open_start[idx] = smp;
        open_vel[idx] = vel;
        r.status = ST_OPEN;
        r.note = note[NOTE_OUT_W-1:0];
        r.vel = vel;
        r.start_smp = smp;
      end
    end else if (open_vel[idx] == '0) begin
      r.status = ST_OFF_OFF;
    end else begin
      r.status = ST_DONE;
      r.note = note[NOTE_OUT_W-1:0];
      r.vel = open_vel[idx];
      r.start_smp = open_start[idx];
      r.stop_smp = smp;
      open_start[idx] = '0;
      open_vel[idx] = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    fail_count++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    interval_t got;
    interval_t want;
    if (rst) begin
      for (int i = 0; i < NOTE_COUNT; i++) begin
        open_start[i] = '0;
        open_vel[i] = '0;
      end
      spt = SPT_RESET;
      interval_q.delete();
    end else begin
      // retire the result first: it always belongs to an older item
      if (res.valid && res.ready) begin
        got = {res.status, res.note_out, res.velocity_out, res.start_sample, res.end_sample};
        if (interval_q.size() == 0) begin
          report_mismatch("unexpected item status", SAMPLE_W'(got.status), '0);
        end else begin
          want = interval_q.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", SAMPLE_W'(got.status), SAMPLE_W'(want.status));
          if (got.note !== want.note)
            report_mismatch("note_out", SAMPLE_W'(got.note), SAMPLE_W'(want.note));
          if (got.vel !== want.vel)
            report_mismatch("velocity_out", SAMPLE_W'(got.vel), SAMPLE_W'(want.vel));
          if (got.start_smp !== want.start_smp)
            report_mismatch("start_sample", got.start_smp, want.start_smp);
          if (got.stop_smp !== want.stop_smp)
            report_mismatch("end_sample", got.stop_smp, want.stop_smp);
        end
      end
      if (evt.valid && evt.ready) begin
        interval_q.insert(interval_q.size(),
                          pair_event(evt.kind, evt.note, evt.velocity, evt.tick_time));
      end
      if (psel && penable && pready && paddr == SPT_ADDR) begin
        if (pwrite) begin
          spt = pwdata[SPT_W-1:0];
        end else if (prdata !== PDATA_W'(spt)) begin
          report_mismatch("samples_per_tick read", SAMPLE_W'(prdata), SAMPLE_W'(spt));
        end
      end
    end
    pending <= interval_q.size();
  end

endmodule

FILE: tb/midi_note_interval_pairer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_interval_pairer_unit_tb
// Drives MIDI events and register writes into the note interval pairer: a
// directed set of corner events, then phases of mostly well-paired random
// note-on/note-off traffic under several samples_per_tick settings, with
// random idling on both channels and one long result stall. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module midi_note_interval_pairer_unit_tb;
  import mnip_pkg::*;

  localparam int LIMIT        = 400000;
  localparam int STALL_CYCLES = 240;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;

  localparam logic [KIND_W-1:0]  KIND_OTHER = 2'd2;
  localparam logic [KIND_W-1:0]  KIND_SPARE = 2'd3;
  localparam logic [PADDR_W-1:0] SPT_ADDR   = {REG_SPT, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  bit                 idle_en;
  bit                 stall_req;
  bit                 note_on [NOTE_COUNT_DEF];
  logic [TICK_W-1:0]  tick_now;

  mnip_evt_if evt_if ();
  mnip_res_if res_if ();

  midi_note_interval_pairer_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .evt     (evt_if),
    .res     (res_if)
  );

  mnip_interval_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .evt        (evt_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("midi_note_interval_pairer_unit test failed");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int stall_left;
    bit stall_taken;
    stall_left = 0;
    stall_taken = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= !idle_en || ($urandom_range(99) >= 35);
      end
    end
  end

  task automatic send_event(input logic [KIND_W-1:0] k, input logic [NOTE_W-1:0] n,
                            input logic [VEL_W-1:0] v, input logic [TICK_W-1:0] t);
    while (idle_en && $urandom_range(99) < 35) begin
      evt_if.valid <= 1'b0;
      @(posedge clk);
    end
    evt_if.valid <= 1'b1;
    evt_if.kind <= k;
    evt_if.note <= n;
    evt_if.velocity <= v;
    evt_if.tick_time <= t;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    // shadow of sounding notes, only used to shape the random traffic
    if (n < NOTE_COUNT_DEF) begin
      if (k == KIND_OFF || (k == KIND_ON && v == '0)) note_on[n] = 1'b0;
      else if (k == KIND_ON) note_on[n] = 1'b1;
    end
  endtask

  task automatic send_random_event();
    logic [KIND_W-1:0] k;
    logic [NOTE_W-1:0] n;
    logic [VEL_W-1:0]  v;
    if ($urandom_range(19) == 0) tick_now = $urandom();
    else tick_now += $urandom_range(3000);
    if ($urandom_range(99) < 85) begin
      // well-formed: close a sounding note, open a silent one
      if ($urandom_range(2) == 0) n = NOTE_W'($urandom_range(127));
      else if ($urandom_range(1) == 0) n = NOTE_W'($urandom_range(7));
      else n = NOTE_W'(120 + $urandom_range(7));
      if (note_on[n]) begin
        if ($urandom_range(3) == 0) begin
          k = KIND_ON;
          v = '0;
        end else begin
          k = KIND_OFF;
          v = VEL_W'($urandom_range(127));
        end
      end else begin
        k = KIND_ON;
        v = VEL_W'($urandom_range(127, 1));
      end
    end else begin
      k = KIND_W'($urandom_range(3));
      n = NOTE_W'($urandom_range(255));
      v = VEL_W'($urandom_range(127));
    end
    send_event(k, n, v, tick_now);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    evt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [SPT_W-1:0] spt_val;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    evt_if.valid = 1'b0;
    evt_if.kind = '0;
    evt_if.note = '0;
    evt_if.velocity = '0;
    evt_if.tick_time = '0;
    idle_en = 1'b1;
    stall_req = 1'b0;
    tick_now = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner events at the reset tick scale
    send_event(KIND_ON, 8'd0, 7'd127, 32'd0);
    send_event(KIND_ON, 8'd0, 7'd1, 32'd10);
    send_event(KIND_OFF, 8'd0, 7'd5, 32'hFFFF_FFFF);
    send_event(KIND_OFF, 8'd0, 7'd0, 32'd20);
    send_event(KIND_ON, 8'd127, 7'd0, 32'd30);
    send_event(KIND_ON, 8'd127, 7'd1, 32'd100);
    // zero-velocity note-on closes, with time running backwards
    send_event(KIND_ON, 8'd127, 7'd0, 32'd50);
    send_event(KIND_OTHER, 8'd200, 7'd64, 32'd123);
    send_event(KIND_SPARE, 8'd255, 7'd127, 32'hFFFF_FFFF);
    send_event(KIND_ON, 8'd128, 7'd127, 32'd1);
    send_event(KIND_OFF, 8'd255, 7'd127, 32'd2);
    send_event(KIND_ON, 8'd128, 7'd0, 32'd3);
    send_event(KIND_ON, 8'd64, 7'd85, 32'h5555_5555);
    send_event(KIND_ON, 8'd64, 7'd42, 32'h5555_5556);
    send_event(KIND_OFF, 8'd64, 7'd127, 32'hAAAA_AAAA);
    send_event(KIND_OTHER, 8'd0, 7'd0, 32'd0);
    wait_quiet();

    // largest scale, upper data bits set and dropped
    apb_write(SPT_ADDR, 32'hFFFF_FFFF);
    apb_read(SPT_ADDR);
    send_event(KIND_ON, 8'd1, 7'd127, 32'hFFFF_FFFF);
    send_event(KIND_OFF, 8'd1, 7'd0, 32'hFFFF_FFFF);
    wait_quiet();

    // zero scale: every sample index collapses to zero
    apb_write(SPT_ADDR, 32'd0);
    send_event(KIND_ON, 8'd2, 7'd9, 32'd1234);
    send_event(KIND_OFF, 8'd2, 7'd9, 32'd5678);
    wait_quiet();
    apb_write(SPARE_ADDR, 32'd1);
    apb_read(SPT_ADDR);
    send_event(KIND_ON, 8'd3, 7'd100, 32'd77);
    send_event(KIND_OFF, 8'd3, 7'd1, 32'd99);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      case (p)
        0: spt_val = 16'd1;
        1: spt_val = 16'hFFFF;
        2: spt_val = 16'd0;
        3: spt_val = SPT_RESET;
        default: spt_val = SPT_W'($urandom_range(65535, 1));
      endcase
      apb_write(SPT_ADDR, {16'($urandom()), spt_val});
      if (p % 3 == 1) apb_write(SPARE_ADDR, $urandom());
      apb_read(SPT_ADDR);
      // one phase runs flat out while the result side holds off
      idle_en = (p != 1);
      if (p == 1) stall_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_event();
    end
    idle_en = 1'b1;
    wait_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("midi_note_interval_pairer_unit test passed");
    end else begin
      $display("midi_note_interval_pairer_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mnip_pkg.sv
src/mnip_evt_if.sv
src/mnip_res_if.sv
src/mnip_ram.sv
src/mnip_ctrl.sv
src/mnip_datapath.sv
src/midi_note_interval_pairer_unit.sv
tb/mnip_interval_checker.sv
tb/midi_note_interval_pairer_unit_tb.sv
